@@ rtl/icalc_pkg.sv @@
package icalc_pkg;

    // fixed width of the result value field
    localparam int OUT_W = 32;

    // ascii codes that the parser looks for
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // sequencer of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_WAIT,
        S_FINAL
    } t_state;

    // states of the shared multiply/divide unit
    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIX
    } t_unit_state;

    // request from the sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_unit_req;

endpackage

@@ rtl/icalc_in_if.sv @@
interface icalc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expr;

    modport source (output valid, output char_code, output end_of_expr, input ready);
    modport sink (input valid, input char_code, input end_of_expr, output ready);
endinterface

@@ rtl/icalc_out_if.sv @@
interface icalc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/icalc_muldiv.sv @@
module icalc_muldiv
    import icalc_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_unit_req    i_req,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    t_unit_state r_ust, n_ust;
    logic          r_is_div;
    logic          r_neg_q;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [CW-1:0] r_cnt;

    logic [W:0] w_opa;
    logic [W:0] w_opb;
    logic [W:0] w_sum;
    logic       w_sub;

    // one shared adder: product accumulate, trial subtract, final negate
    always_comb begin
        w_opa = {1'b0, r_acc};
        w_opb = {1'b0, r_x};
        w_sub = 1'b0;
        if (r_ust == U_RUN && r_is_div) begin
            w_opa = {r_acc, r_x[W-1]};
            w_opb = {1'b0, r_y};
            w_sub = 1'b1;
        end else if (r_ust == U_FIX) begin
            w_opa = '0;
            w_opb = {1'b0, r_x};
            w_sub = 1'b1;
        end
        w_sum = w_opa + (w_sub ? ~w_opb : w_opb) + {{W{1'b0}}, w_sub};
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ust <= U_IDLE;
        end else begin
            r_ust <= n_ust;
        end
    end

    // next state
    always_comb begin
        n_ust = r_ust;
        case (r_ust)
            U_IDLE: begin
                if (i_req.start) begin
                    n_ust = U_RUN;
                end
            end
            U_RUN: begin
                if (r_cnt == '0) begin
                    n_ust = U_FIX;
                end
            end
            U_FIX: begin
                n_ust = U_IDLE;
            end
            default: begin
                n_ust = U_IDLE;
            end
        endcase
    end

    // datapath: one bit of product or quotient per cycle
    always_ff @(posedge i_clk) begin
        if (r_ust == U_IDLE && i_req.start) begin
            r_is_div <= i_req.is_div;
            r_acc    <= '0;
            r_cnt    <= CW'(W - 1);
            if (i_req.is_div) begin
                r_x     <= i_a[W-1] ? (~i_a) + ONE : i_a;
                r_y     <= i_b[W-1] ? (~i_b) + ONE : i_b;
                r_neg_q <= i_a[W-1] ^ i_b[W-1];
            end else begin
                r_x     <= i_a;
                r_y     <= i_b;
                r_neg_q <= 1'b0;
            end
        end else if (r_ust == U_RUN) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_is_div) begin
                if (!w_sum[W]) begin
                    r_acc <= w_sum[W-1:0];
                    r_x   <= {r_x[W-2:0], 1'b1};
                end else begin
                    r_acc <= w_opa[W-1:0];
                    r_x   <= {r_x[W-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_acc <= w_sum[W-1:0];
                end
                r_x <= {r_x[W-2:0], 1'b0};
                r_y <= {1'b0, r_y[W-1:1]};
            end
        end
    end

    // result is valid in the sign fix cycle
    assign o_done   = (r_ust == U_FIX);
    assign o_result = r_is_div ? (r_neg_q ? w_sum[W-1:0] : r_x) : r_acc;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_ust == U_IDLE)
        else $error("unit started while busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ust == U_RUN && r_is_div) |-> r_acc < r_y)
        else $error("partial remainder not below divisor");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_ust == U_IDLE)
        else $error("unit did not return to idle after done");

endmodule

@@ rtl/infix_calculator_stream.sv @@
// Streaming infix calculator.
// Input channel i_in: one ascii character per beat (char_code) with end_of_expr
// set on the last character. Digits build non-negative decimal operands;
// + - * / are operators, * and / binding tighter; everything else is ignored.
// Output channel o_out: one beat per expression after its last character,
// carrying value (modulo 2^VALUE_WIDTH, fitted to OUT_W bits, zero when
// status is not ok) and status (ok, divide by zero, missing operand).
// A digit or an ignored character is taken directly. An operator that follows
// a digit closes the pending operation: + or - and a divide by zero are done
// in the sequencer, * or / in the bit-serial multiply/divide unit with a
// shared adder, and no new character is taken until it is closed. The last
// character closes the pending operation too and then forms the result,
// whose write to the output register may wait for o_out.ready.
// i_in.ready is high only while the sequencer waits for a character.
// The result sits in an output register; a new expression is taken in while
// it waits, and only the next result waits for o_out.ready.
// Reset (synchronous, active low) clears the evaluation state and drops any
// pending output beat; after each result the evaluation state clears again.
module infix_calculator_stream
    import icalc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    icalc_in_if.sink     i_in,
    icalc_out_if.source  o_out
);

    localparam int W = VALUE_WIDTH;

    t_state r_state, n_state;
    logic [W-1:0] r_total, n_total;
    logic [W-1:0] r_term, n_term;
    logic         r_term_neg, n_term_neg;
    t_op          r_pend, n_pend;
    logic [W-1:0] r_acc, n_acc;
    logic         r_seen, n_seen;
    t_status      r_fault, n_fault;
    t_op          r_new_op, n_new_op;
    logic         r_set_op, n_set_op;
    logic         r_last, n_last;
    logic         r_final_ok, n_final_ok;
    logic         r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_value, n_out_value;
    t_status      r_out_status, n_out_status;

    t_unit_req    w_req;
    logic         w_done;
    logic [W-1:0] w_result;

    logic         w_is_digit;
    logic         w_is_op;
    t_op          w_op_code;
    logic [7:0]   w_digit;
    logic [W-1:0] w_acc_next;
    logic [W-1:0] w_total_sum;
    t_status      w_fin_status;
    logic [W-1:0] w_fin_value;
    logic [OUT_W-1:0] w_fin_out;

    // character decode
    always_comb begin
        w_is_digit = i_in.char_code inside {[CH_ZERO:CH_NINE]};
        w_is_op    = i_in.char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        case (i_in.char_code)
            CH_PLUS:  w_op_code = OP_ADD;
            CH_MINUS: w_op_code = OP_SUB;
            CH_STAR:  w_op_code = OP_MUL;
            default:  w_op_code = OP_DIV;
        endcase
        w_digit = i_in.char_code - CH_ZERO;
    end

    // operand times ten plus digit, as two shifts and two adds
    assign w_acc_next = {r_acc[W-4:0], 3'b000} + {r_acc[W-2:0], 1'b0}
                      + {{(W-4){1'b0}}, w_digit[3:0]};

    // close the open term into the running total
    assign w_total_sum = r_term_neg ? r_total - r_term : r_total + r_term;

    // final status and value
    always_comb begin
        if (r_final_ok) begin
            w_fin_status = r_fault;
        end else if (r_fault != ST_OK) begin
            w_fin_status = r_fault;
        end else begin
            w_fin_status = ST_MISSING;
        end
        w_fin_value = (r_final_ok && w_fin_status == ST_OK) ? w_total_sum : '0;
    end

    // fit the value to the output field
    generate
        if (W >= OUT_W) begin : g_trunc
            assign w_fin_out = w_fin_value[OUT_W-1:0];
        end else begin : g_extend
            assign w_fin_out = {{(OUT_W-W){1'b0}}, w_fin_value};
        end
    endgenerate

    // shared multiply/divide unit
    icalc_muldiv #(
        .W (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (r_term),
        .i_b      (r_acc),
        .o_done   (w_done),
        .o_result (w_result)
    );

    // state and evaluation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_term      <= '0;
            r_term_neg  <= 1'b0;
            r_pend      <= OP_ADD;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_fault     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_term      <= n_term;
            r_term_neg  <= n_term_neg;
            r_pend      <= n_pend;
            r_acc       <= n_acc;
            r_seen      <= n_seen;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_new_op     <= n_new_op;
        r_set_op     <= n_set_op;
        r_last       <= n_last;
        r_final_ok   <= n_final_ok;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_term       = r_term;
        n_term_neg   = r_term_neg;
        n_pend       = r_pend;
        n_acc        = r_acc;
        n_seen       = r_seen;
        n_fault      = r_fault;
        n_new_op     = r_new_op;
        n_set_op     = r_set_op;
        n_last       = r_last;
        n_final_ok   = r_final_ok;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_req        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_last     = i_in.end_of_expr;
                    n_set_op   = 1'b0;
                    n_final_ok = 1'b0;
                    if (w_is_digit) begin
                        n_acc  = w_acc_next;
                        n_seen = 1'b1;
                        if (i_in.end_of_expr) begin
                            n_final_ok = 1'b1;
                            n_state    = S_APPLY;
                        end
                    end else if (w_is_op && r_seen) begin
                        n_new_op = w_op_code;
                        n_set_op = 1'b1;
                        n_state  = S_APPLY;
                    end else if (i_in.end_of_expr) begin
                        n_final_ok = r_seen;
                        n_state    = r_seen ? S_APPLY : S_FINAL;
                    end
                end
            end
            S_APPLY: begin
                n_acc  = '0;
                n_seen = 1'b0;
                if (r_set_op) begin
                    n_pend = r_new_op;
                end
                case (r_pend)
                    OP_ADD, OP_SUB: begin
                        n_total    = w_total_sum;
                        n_term     = r_acc;
                        n_term_neg = (r_pend == OP_SUB);
                        n_state    = r_last ? S_FINAL : S_IDLE;
                    end
                    OP_MUL: begin
                        w_req.start  = 1'b1;
                        w_req.is_div = 1'b0;
                        n_state      = S_WAIT;
                    end
                    default: begin
                        if (r_acc == '0) begin
                            if (r_fault == ST_OK) begin
                                n_fault = ST_DIV0;
                            end
                            n_term  = '0;
                            n_state = r_last ? S_FINAL : S_IDLE;
                        end else begin
                            w_req.start  = 1'b1;
                            w_req.is_div = 1'b1;
                            n_state      = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                if (w_done) begin
                    n_term  = w_result;
                    n_state = r_last ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_fin_out;
                    n_out_status = w_fin_status;
                    n_total      = '0;
                    n_term       = '0;
                    n_term_neg   = 1'b0;
                    n_pend       = OP_ADD;
                    n_acc        = '0;
                    n_seen       = 1'b0;
                    n_fault      = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ports
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_WAIT)
        else $error("multiply/divide result outside wait state");

    a_final_no_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINAL |-> !r_seen)
        else $error("pending operand not applied before final");

    a_fault_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> r_out_value == '0)
        else $error("nonzero value with fault status");

endmodule
